// ===== hw/rtl/lbc_pkg.sv =====
`timescale 1ns / 1ps
package lbc_pkg;

    localparam int NUM_LEDS = 4;
    localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [IDX_W-1:0] LAST_CHAN = IDX_W'(NUM_LEDS - 1);

    localparam int CNT_W = 8;
    localparam int TOG_W = 9;
    localparam int DUTY_W = 7;
    localparam int PER_W = 16;
    localparam int PROD_W = DUTY_W + PER_W;

    localparam logic [DUTY_W-1:0] PCT_FULL = DUTY_W'(100);

    // floor(x / 100) == (x * RECIP_K) >> RECIP_S for every x below 100 * 2^16
    localparam int RECIP_S = 30;
    localparam int RECIP_W = 24;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(10737419);
    localparam int SCALED_W = PROD_W + RECIP_W;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;
    localparam int PIN_W = 4;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic [TOG_W-1:0]  toggles_left;
        logic              stop_pending;
        logic [DUTY_W-1:0] chan_duty;
        logic [PER_W-1:0]  chan_period;
        logic [PER_W-1:0]  wait_ticks;
    } chan_rec_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        chan_rec_t        wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

// ===== hw/rtl/lbc_chan_mem.sv =====
`timescale 1ns / 1ps
module lbc_chan_mem (
    input  logic              aclk,
    input  lbc_pkg::mem_req_t req,
    output lbc_pkg::chan_rec_t rdata
);
    import lbc_pkg::*;

    chan_rec_t mem [NUM_LEDS];
    chan_rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lbc_duty_calc.sv =====
`timescale 1ns / 1ps
module lbc_duty_calc (
    input  logic                       aclk,
    input  logic                       load,
    input  logic [lbc_pkg::DUTY_W-1:0] duty,
    input  logic [lbc_pkg::PER_W-1:0]  period,
    output logic [lbc_pkg::PER_W-1:0]  on_time
);
    import lbc_pkg::*;

    logic [PROD_W-1:0]   prod_reg;
    logic [SCALED_W-1:0] scaled_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= PROD_W'(duty) * PROD_W'(period);
        end
        scaled_reg <= SCALED_W'(prod_reg) * SCALED_W'(RECIP_K);
    end

    assign on_time = scaled_reg[RECIP_S +: PER_W];

endmodule

// ===== hw/rtl/multi_led_blink_controller.sv =====
`timescale 1ns / 1ps
// A start beat's result is registered and valid in the cycle after its acceptance.
// A tick beat walks the channel records in memory, one at a time: read, then evaluate,
// plus multiply and write-back when the channel toggles (two multiply stages for
// on-time), then a done state. Throughput: one beat at a time; start beats can follow
// every cycle while results are taken; a tick beat holds off new beats until it ends.
// Reset (aresetn low, synchronous): all channels idle, all pins off, no result pending.
module multi_led_blink_controller (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // tdata: led_sel[1:0], blink_count[9:2], duty_percent[16:10], period_ticks[32:17]
    input  logic [lbc_pkg::S_DATA_W-1:0] s_tdata,
    // tuser: opcode[0]
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // tdata: led_pins[3:0], active_mask[7:4]
    output logic [lbc_pkg::M_DATA_W-1:0] m_tdata
);
    import lbc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_WB   = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    chan_reg, chan_next;
    logic [NUM_LEDS-1:0] act_reg, act_next;
    logic [NUM_LEDS-1:0] pin_reg, pin_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    chan_rec_t           rec_reg, rec_next;

    mem_req_t           mreq;
    chan_rec_t          rdata;
    logic               calc_load;
    logic [PER_W-1:0]   on_time;

    logic [1:0]        in_idx;
    logic [CNT_W-1:0]  in_count;
    logic [DUTY_W-1:0] in_duty;
    logic [PER_W-1:0]  in_period;
    logic              s_beat;
    logic              idx_ok;
    logic [PER_W-1:0]  left;

    assign in_idx    = s_tdata[1:0];
    assign in_count  = s_tdata[9:2];
    assign in_duty   = s_tdata[16:10];
    assign in_period = s_tdata[32:17];

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_beat   = s_tvalid && s_tready;
    assign idx_ok   = 32'(in_idx) < NUM_LEDS;
    assign left     = (rdata.wait_ticks != '0) ? rdata.wait_ticks - PER_W'(1) : '0;

    lbc_chan_mem u_mem (
        .aclk  (aclk),
        .req   (mreq),
        .rdata (rdata)
    );

    lbc_duty_calc u_calc (
        .aclk    (aclk),
        .load    (calc_load),
        .duty    (rec_next.chan_duty),
        .period  (rec_next.chan_period),
        .on_time (on_time)
    );

    function automatic logic [M_DATA_W-1:0] pack_out(
        input logic [NUM_LEDS-1:0] pins,
        input logic [NUM_LEDS-1:0] act
    );
        logic [M_DATA_W-1:0] r;
        r = '0;
        for (int i = 0; i < PIN_W; i++) begin
            if (i < NUM_LEDS) begin
                r[i]         = pins[i];
                r[PIN_W + i] = act[i];
            end
        end
        return r;
    endfunction

    always_comb begin
        state_next    = state_reg;
        chan_next     = chan_reg;
        act_next      = act_reg;
        pin_next      = pin_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        rec_next      = rec_reg;
        calc_load     = 1'b0;
        mreq.we       = 1'b0;
        mreq.waddr    = chan_reg;
        mreq.wdata    = rec_reg;
        mreq.raddr    = chan_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    if (s_tuser == OP_START) begin
                        if (idx_ok) begin
                            mreq.we                  = 1'b1;
                            mreq.waddr               = IDX_W'(in_idx);
                            mreq.wdata.toggles_left  = {in_count, 1'b0};
                            mreq.wdata.stop_pending  = 1'b0;
                            mreq.wdata.chan_duty     = (in_duty > PCT_FULL) ? PCT_FULL : in_duty;
                            mreq.wdata.chan_period   = in_period;
                            mreq.wdata.wait_ticks    = '0;
                            act_next[IDX_W'(in_idx)] = 1'b1;
                            pin_next[IDX_W'(in_idx)] = 1'b0;
                        end
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = pack_out(pin_next, act_next);
                    end else begin
                        chan_next  = '0;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                rec_next   = rdata;
                state_next = (chan_reg == LAST_CHAN) ? ST_DONE : ST_RD;
                chan_next  = (chan_reg == LAST_CHAN) ? chan_reg : chan_reg + IDX_W'(1);
                if (act_reg[chan_reg]) begin
                    if (left != '0) begin
                        mreq.we               = 1'b1;
                        mreq.wdata            = rdata;
                        mreq.wdata.wait_ticks = left;
                    end else if (rdata.stop_pending) begin
                        act_next[chan_reg]    = 1'b0;
                        mreq.we               = 1'b1;
                        mreq.wdata            = rdata;
                        mreq.wdata.wait_ticks = '0;
                    end else begin
                        if (rdata.toggles_left != '0) begin
                            rec_next.toggles_left = rdata.toggles_left - TOG_W'(1);
                            if (rdata.toggles_left == TOG_W'(1)) begin
                                rec_next.stop_pending = 1'b1;
                            end
                        end
                        pin_next[chan_reg] = !pin_reg[chan_reg];
                        calc_load          = 1'b1;
                        chan_next          = chan_reg;
                        state_next         = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                mreq.we               = 1'b1;
                mreq.wdata.wait_ticks = pin_reg[chan_reg] ? on_time
                                                          : rec_reg.chan_period - on_time;
                state_next = (chan_reg == LAST_CHAN) ? ST_DONE : ST_RD;
                chan_next  = (chan_reg == LAST_CHAN) ? chan_reg : chan_reg + IDX_W'(1);
            end
            ST_DONE: begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = pack_out(pin_reg, act_reg);
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chan_reg     <= '0;
            act_reg      <= '0;
            pin_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chan_reg     <= chan_next;
            act_reg      <= act_next;
            pin_reg      <= pin_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        rec_reg     <= rec_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
